FILE: design/cbmd_pkg.sv
// Package for the bus memory-map decoder: access and target codes, bank and
// register addresses, and the item, result, state and configuration structs.
// It depends on nothing else.
`timescale 1ns / 1ps

package cbmd_pkg;

  localparam int DEF_RAM_ADDR_BITS  = 16;
  localparam int DEF_SRAM_ADDR_BITS = 16;
  localparam int DEF_LAST_ROM_BANK  = 11;

  localparam int ADDR_W      = 24;
  localparam int OFFSET_W    = 23;
  localparam int VALUE_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 4;

  typedef enum logic [1:0] {
    OP_READ_BYTE  = 2'd0,
    OP_READ_WORD  = 2'd1,
    OP_WRITE_BYTE = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    TGT_CONST = 4'd0,
    TGT_ROM   = 4'd1,
    TGT_SRAM  = 4'd2,
    TGT_WRAM  = 4'd3,
    TGT_VDATA = 4'd4,
    TGT_VSTAT = 4'd5,
    TGT_HV    = 4'd6,
    TGT_V     = 4'd7,
    TGT_H     = 4'd8
  } target_t;

  typedef enum logic [1:0] {
    LANE_WORD = 2'd0,
    LANE_LOW  = 2'd1,
    LANE_HIGH = 2'd2
  } lane_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SRAM_ENABLED = 3'd0,
    CFG_SRAM_CUSTOM  = 3'd1,
    CFG_SRAM_BASE    = 3'd2,
    CFG_SRAM_TOP     = 3'd3,
    CFG_REGION_WEST  = 3'd4,
    CFG_VIDEO_PAL    = 3'd5
  } cfg_index_t;

  localparam logic [4:0] SRAM_BANK   = 5'h04;
  localparam logic [4:0] IO_BANK     = 5'h14;
  localparam logic [4:0] VIDEO_FIRST = 5'h18;
  localparam logic [4:0] VIDEO_LAST  = 5'h1B;
  localparam logic [4:0] WRAM_FIRST  = 5'h1C;

  localparam logic [ADDR_W-1:0] VIDEO_HOLE_MASK  = 24'h0700E0;
  localparam logic [ADDR_W-1:0] BUSREQ_ADDR      = 24'hA11100;
  localparam logic [ADDR_W-1:0] SOUND_RESET_ADDR = 24'hA11200;
  localparam logic [ADDR_W-1:0] SRAM_CTRL_ADDR   = 24'hA130F1;
  localparam logic [ADDR_W-1:0] IO_LAST_ADDR     = 24'hA1000D;
  localparam logic [ADDR_W-1:0] SOUND_LAST_ADDR  = 24'hA0FFFF;

  localparam logic [VALUE_W-1:0] BUSREQ_WORD  = 16'h8100;
  localparam logic [VALUE_W-1:0] BUSREQ_BYTE  = 16'h0081;
  localparam logic [VALUE_W-1:0] VERSION_BASE = 16'h0020;
  localparam logic [VALUE_W-1:0] PAD_BYTE     = 16'h00FF;
  localparam logic [VALUE_W-1:0] PAD_WORD_HI  = 16'hFF00;

  localparam logic [ADDR_W-1:0] SRAM_BASE_RESET = 24'h200000;
  localparam logic [ADDR_W-1:0] SRAM_TOP_RESET  = 24'h20FFFF;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
    logic              bus_flag;
  } item_t;

  typedef struct packed {
    target_t             target;
    logic [OFFSET_W-1:0] offset;
    logic                is_write;
    lane_t               lane;
    logic [VALUE_W-1:0]  value;
  } result_t;

  typedef struct packed {
    logic       sram_mapped;
    logic       sound_in_reset;
    logic [7:0] fetch_toggle;
  } state_t;

  typedef struct packed {
    logic              sram_enabled;
    logic              sram_custom;
    logic [ADDR_W-1:0] sram_base;
    logic [ADDR_W-1:0] sram_top;
    logic              region_west;
    logic              video_pal;
  } cfg_t;

endpackage

FILE: design/cbmd_decode.sv
// Combinational decode of one bus access into a target, offset and value,
// together with the next value of the decoder state. Depends on cbmd_pkg.
`timescale 1ns / 1ps

module cbmd_decode #(
  parameter int RAM_ADDR_BITS  = cbmd_pkg::DEF_RAM_ADDR_BITS,
  parameter int SRAM_ADDR_BITS = cbmd_pkg::DEF_SRAM_ADDR_BITS,
  parameter int LAST_ROM_BANK  = cbmd_pkg::DEF_LAST_ROM_BANK
) (
  input  cbmd_pkg::item_t   item,
  input  cbmd_pkg::cfg_t    cfg,
  input  cbmd_pkg::state_t  st,
  output cbmd_pkg::result_t res,
  output cbmd_pkg::state_t  st_nxt
);
  import cbmd_pkg::*;

  localparam logic [OFFSET_W-1:0] RAM_MASK  = OFFSET_W'((1 << RAM_ADDR_BITS) - 1);
  localparam logic [OFFSET_W-1:0] SRAM_MASK = OFFSET_W'((1 << SRAM_ADDR_BITS) - 1);
  localparam logic [4:0]          ROM_LAST  = 5'(LAST_ROM_BANK);

  logic [4:0]          bank;
  logic [4:0]          port_sel;
  logic [ADDR_W-1:0]   a;
  logic [ADDR_W-1:0]   sram_diff;
  logic [OFFSET_W-1:0] sram_off;
  logic [OFFSET_W-1:0] ram_off;
  logic                win;
  logic                is_word;
  logic [VALUE_W-1:0]  version;
  logic [VALUE_W-1:0]  io_val;
  logic [7:0]          fake_flip;

  assign a         = item.address;
  assign bank      = a[23:19];
  assign port_sel  = a[4:0];
  assign is_word   = (item.op == OP_READ_WORD);
  assign sram_diff = a - cfg.sram_base;
  assign sram_off  = sram_diff[OFFSET_W-1:0] & SRAM_MASK;
  assign ram_off   = a[OFFSET_W-1:0] & RAM_MASK;
  assign win       = (bank == SRAM_BANK) && st.sram_mapped && cfg.sram_enabled &&
                     (a >= cfg.sram_base) && (a <= cfg.sram_top);
  assign version   = VERSION_BASE | {8'd0, cfg.region_west, cfg.video_pal, 6'd0};
  assign fake_flip = ~st.fetch_toggle;

  always_comb begin
    io_val = '0;
    priority if (a <= SOUND_LAST_ADDR) begin
      io_val = '0;
    end else if (a == BUSREQ_ADDR) begin
      priority if (!item.bus_flag) begin
        io_val = '0;
      end else if (!is_word) begin
        io_val = BUSREQ_BYTE;
      end else begin
        io_val = BUSREQ_WORD | {8'd0, fake_flip};
      end
    end else if (a > IO_LAST_ADDR) begin
      io_val = '0;
    end else begin
      unique case (a[3:1])
        3'd0:                      io_val = version;
        3'd1, 3'd2, 3'd4, 3'd5:    io_val = PAD_BYTE;
        3'd3:                      io_val = is_word ? PAD_WORD_HI : PAD_BYTE;
        default:                   io_val = '0;
      endcase
    end
  end

  always_comb begin
    res.target   = TGT_CONST;
    res.offset   = '0;
    res.is_write = 1'b0;
    res.lane     = LANE_WORD;
    res.value    = '0;
    st_nxt       = st;

    priority if (item.op == OP_NONE) begin
      res.target = TGT_CONST;
    end else if (bank <= ROM_LAST) begin
      priority if (item.op == OP_WRITE_BYTE) begin
        if (win) begin
          res.target   = TGT_SRAM;
          res.offset   = sram_off;
          res.is_write = 1'b1;
        end
      end else if (win) begin
        if (!cfg.sram_custom) begin
          res.target = TGT_SRAM;
          res.offset = sram_off;
        end
      end else if (item.op == OP_READ_BYTE) begin
        res.target = TGT_ROM;
        res.offset = a[22:0];
      end else begin
        res.target = TGT_ROM;
        res.offset = {1'b0, a[22:1]};
      end
    end else if (bank == IO_BANK) begin
      if (item.op == OP_WRITE_BYTE) begin
        priority if (a == SOUND_RESET_ADDR) begin
          st_nxt.sound_in_reset = ~item.write_data[0];
        end else if (a == SRAM_CTRL_ADDR) begin
          st_nxt.sram_mapped = item.write_data[0];
        end else begin
          st_nxt = st;
        end
      end else begin
        res.value = io_val;
        if (is_word && item.bus_flag && (a == BUSREQ_ADDR)) begin
          st_nxt.fetch_toggle = fake_flip;
        end
      end
    end else if ((bank >= VIDEO_FIRST) && (bank <= VIDEO_LAST)) begin
      if ((a & VIDEO_HOLE_MASK) == '0) begin
        unique case (item.op)
          OP_READ_BYTE: begin
            priority if (port_sel[4:2] == 3'b001) begin
              res.target = TGT_VSTAT;
              res.lane   = port_sel[0] ? LANE_HIGH : LANE_LOW;
            end else if (port_sel == 5'd8) begin
              res.target = TGT_V;
            end else if (port_sel == 5'd9) begin
              res.target = TGT_H;
            end else begin
              res.target = TGT_CONST;
            end
          end
          OP_READ_WORD: begin
            priority if (port_sel < 5'd4) begin
              res.target = TGT_VDATA;
            end else if (port_sel < 5'd8) begin
              res.target = TGT_VSTAT;
            end else if (port_sel < 5'd10) begin
              res.target = TGT_HV;
            end else begin
              res.target = TGT_CONST;
            end
          end
          default: begin
            if (port_sel < 5'd4) begin
              res.target   = TGT_VDATA;
              res.is_write = 1'b1;
            end
          end
        endcase
      end
    end else if (bank >= WRAM_FIRST) begin
      res.target   = TGT_WRAM;
      res.offset   = is_word ? (ram_off & ~OFFSET_W'(1)) : ram_off;
      res.is_write = (item.op == OP_WRITE_BYTE);
    end else begin
      res.target = TGT_CONST;
    end
  end

endmodule

FILE: design/cpu_bus_memory_map_decoder_unit.sv
// Top level of the bus memory-map decoder: stream ports, input register,
// result register, decoder state and configuration registers.
// Depends on cbmd_pkg and cbmd_decode.
`timescale 1ns / 1ps

// The block takes one bus access per item on the in_ channel and returns
// exactly one result item on the out_ channel for each, in order.
// An item is accepted when tvalid and tready are both high. It lands in the
// input register, is decoded by cbmd_decode and moves on into the result
// register, which drives out_tvalid. While out_tready stays high, throughput
// is one item per cycle: the input register and the result register each
// advance whenever the stage after them is empty or is being emptied.
// The decoder state (battery RAM mapping, sound CPU reset flag, fake fetch
// byte) is updated as an item moves into the result register, so every item
// sees the state left by the one before it.
// When the receiver holds out_tready low, the result stays in place, one more
// item waits in the input register, and in_tready then goes low.
// The configuration port writes a register at any edge with cfg_we high; it is
// meant to be used only while no item is in flight.
// Synchronous reset empties both registers, restores the configuration
// defaults, unmaps battery RAM, holds the sound CPU in reset and clears the
// fake fetch byte.
module cpu_bus_memory_map_decoder_unit #(
  parameter int RAM_ADDR_BITS  = cbmd_pkg::DEF_RAM_ADDR_BITS,
  parameter int SRAM_ADDR_BITS = cbmd_pkg::DEF_SRAM_ADDR_BITS,
  parameter int LAST_ROM_BANK  = cbmd_pkg::DEF_LAST_ROM_BANK
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // address[23:0], write_data[31:24], sound_cpu_bus_flag[32], zeros above
  input  logic [cbmd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // operation[1:0]
  input  logic [cbmd_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // target_offset[22:0], is_write[23], status_lane[25:24], read_value[41:26],
  // zeros above
  output logic [cbmd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // target[3:0]
  output logic [cbmd_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  logic                                 cfg_we,
  input  logic [cbmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cbmd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cbmd_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  state_t  state_r;
  cfg_t    cfg_r, cfg_nxt;

  result_t dec_res;
  state_t  state_nxt;
  item_t   in_item;
  logic    in_accept;
  logic    s1_move;

  assign in_item.op         = op_t'(in_tuser);
  assign in_item.address    = in_tdata[23:0];
  assign in_item.write_data = in_tdata[31:24];
  assign in_item.bus_flag   = in_tdata[32];

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_tready);

  cbmd_decode #(
    .RAM_ADDR_BITS  (RAM_ADDR_BITS),
    .SRAM_ADDR_BITS (SRAM_ADDR_BITS),
    .LAST_ROM_BANK  (LAST_ROM_BANK)
  ) u_decode (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .res    (dec_res),
    .st_nxt (state_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRAM_ENABLED: cfg_nxt.sram_enabled = cfg_wdata[0];
        CFG_SRAM_CUSTOM:  cfg_nxt.sram_custom  = cfg_wdata[0];
        CFG_SRAM_BASE:    cfg_nxt.sram_base    = cfg_wdata[ADDR_W-1:0];
        CFG_SRAM_TOP:     cfg_nxt.sram_top     = cfg_wdata[ADDR_W-1:0];
        CFG_REGION_WEST:  cfg_nxt.region_west  = cfg_wdata[0];
        CFG_VIDEO_PAL:    cfg_nxt.video_pal    = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      state_r.sram_mapped    <= 1'b0;
      state_r.sound_in_reset <= 1'b1;
      state_r.fetch_toggle   <= '0;
      cfg_r.sram_enabled   <= 1'b0;
      cfg_r.sram_custom    <= 1'b0;
      cfg_r.sram_base      <= SRAM_BASE_RESET;
      cfg_r.sram_top       <= SRAM_TOP_RESET;
      cfg_r.region_west    <= 1'b0;
      cfg_r.video_pal      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      if (s1_move) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (s1_move) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.target;
  assign out_tdata  = {6'd0, out_res_r.value, out_res_r.lane,
                       out_res_r.is_write, out_res_r.offset};

  a_fake_only_busreq: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (state_nxt.fetch_toggle != state_r.fetch_toggle) |->
      (s1_item_r.op == OP_READ_WORD) && (s1_item_r.address == BUSREQ_ADDR))
    else $error("fake fetch byte changed outside a bus request word read");

  a_map_only_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (state_nxt.sram_mapped != state_r.sram_mapped) |->
      (s1_item_r.op == OP_WRITE_BYTE) && (s1_item_r.address == SRAM_CTRL_ADDR))
    else $error("battery RAM mapping changed outside its control register");

  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.is_write |->
      (out_res_r.target == TGT_SRAM) || (out_res_r.target == TGT_WRAM) ||
      (out_res_r.target == TGT_VDATA))
    else $error("write flag set for a target that takes no writes");

  a_lane_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.lane != LANE_WORD) |-> (out_res_r.target == TGT_VSTAT))
    else $error("status lane set for a target other than video status");

  a_value_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.value != '0) |-> (out_res_r.target == TGT_CONST))
    else $error("read value set for a target other than a constant");

endmodule
